// ===== rtl/kpu_pkg.sv =====
// Shared types, constants and the factorial lookup for the permutation unranker.
// No dependencies; every other file of the block imports this package.
package kpu_pkg;

    localparam int SYM_W  = 4;
    localparam int RANK_W = 19;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } state_t;

    // Control word broadcast from the sequencer to every symbol cell.
    typedef struct packed {
        logic             load;
        logic             advance;
        logic [SYM_W-1:0] sel;
    } cell_ctrl_t;

    // Returns i! for i from 0 to 9, and 0 for codes that have no meaning here.
    function automatic logic [RANK_W-1:0] fact_of(input logic [SYM_W-1:0] i);
        logic [RANK_W-1:0] f;
        case (i)
            4'd0:    f = 19'd1;
            4'd1:    f = 19'd1;
            4'd2:    f = 19'd2;
            4'd3:    f = 19'd6;
            4'd4:    f = 19'd24;
            4'd5:    f = 19'd120;
            4'd6:    f = 19'd720;
            4'd7:    f = 19'd5040;
            4'd8:    f = 19'd40320;
            4'd9:    f = 19'd362880;
            default: f = 19'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/kpu_cell.sv =====
// One cell of the unused-symbol list.
// Depends on kpu_pkg for the control word type.
module kpu_cell
    import kpu_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [SYM_W-1:0] right,
    output logic [SYM_W-1:0] sym
);

    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;

    // When a symbol at or left of this cell is taken, the list closes the gap.
    always_comb
    begin
        sym_next = sym_reg;
        if (ctrl.load)
        begin
            sym_next = SYM_W'(IDX + 1);
        end
        else if (ctrl.advance && (ctrl.sel <= SYM_W'(IDX)))
        begin
            sym_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg <= '0;
        end
        else
        begin
            sym_reg <= sym_next;
        end
    end

    assign sym = sym_reg;

endmodule

// ===== rtl/kth_permutation_unrank_top.sv =====
// Top level of the lexicographic permutation unranker.
// Depends on kpu_pkg and instantiates a row of kpu_cell.
//
// Each input word carries a symbol count n and a one-based rank k, and the block
// answers with the n symbols of the k-th permutation of 1..n in ascending
// lexicographic order, one output word per symbol, most significant first, with
// last set on the n-th word. A count of zero or above MAX_SYMBOLS, or a rank of
// zero or above n!, yields a single word with digit 0 and both last and error
// set. The unused symbols live in a row of MAX_SYMBOLS cells, smallest first.
// For every position the sequencer compares the remaining rank against all
// multiples of the current factorial at once, which gives the index of the
// symbol to take; that cell's symbol is emitted and the cells above it each
// shift down by one, so the row stays sorted. An input word is taken while the
// block is idle; then one output word is produced per cycle whenever the output
// register is free, that is empty or not stalled, and an erroneous item yields
// its single error word the same way. The next input word is accepted as
// soon as the last output word has been placed in the output register, even if
// that word has not yet been taken.
module kth_permutation_unrank_top
    import kpu_pkg::*;
#(
    parameter int MAX_SYMBOLS = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [SYM_W-1:0]  count,
    input  logic [RANK_W-1:0] rank,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SYM_W-1:0]  digit,
    output logic              last,
    output logic              error
);

    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    state_t            state_reg, state_next;
    logic [RANK_W-1:0] r_reg, r_next;
    logic [SYM_W-1:0]  rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  digit_reg, digit_next;
    logic              last_reg, last_next;
    logic              error_reg, error_next;

    logic              in_take;
    logic              in_bad;
    logic              out_free;
    cell_ctrl_t        ctrl;
    logic [SYM_W-1:0]  cell_sym [MAX_SYMBOLS];
    logic [RANK_W-1:0] thr [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] ge;
    logic [SYM_W-1:0]  sel;
    logic [RANK_W-1:0] fact_rem;

    // The input side is free whenever no item is being worked on.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign in_bad = (count == '0) || (count > SYM_W'(MAX_SYMBOLS)) ||
                    (rank == '0) || (rank > fact_of(count));

    // The multiples j * (rem)! for j = 0 .. MAX_SYMBOLS-1. The remaining rank is
    // always below (rem+1)!, so the number of multiples it reaches is the index
    // of the symbol to take.
    assign fact_rem = fact_of(rem_reg);

    always_comb
    begin
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            thr[j] = RANK_W'(fact_rem * RANK_W'(j));
            ge[j]  = (j != 0) && (r_reg >= thr[j]);
        end
    end

    always_comb
    begin
        sel = '0;
        for (int j = 1; j < MAX_SYMBOLS; j++)
        begin
            sel = sel + SYM_W'(ge[j]);
        end
    end

    // Sequencer: next state, remaining rank and the output register.
    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        digit_next     = digit_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        ctrl.load      = 1'b0;
        ctrl.advance   = 1'b0;
        ctrl.sel       = sel;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    ctrl.load = 1'b1;
                    r_next    = rank - RANK_W'(1);
                    rem_next  = count - SYM_W'(1);
                    state_next = in_bad ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    ctrl.advance   = 1'b1;
                    out_valid_next = 1'b1;
                    digit_next     = cell_sym[sel[IDX_W-1:0]];
                    last_next      = (rem_reg == '0);
                    error_next     = 1'b0;
                    r_next         = r_reg - thr[sel[IDX_W-1:0]];
                    rem_next       = rem_reg - SYM_W'(1);
                    if (rem_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = '0;
                    last_next      = 1'b1;
                    error_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
        error_reg <= error_next;
    end

    // Row of symbol cells; on a shift, each cell at or above the taken index takes its right neighbor's symbol.
    for (genvar i = 0; i < MAX_SYMBOLS; i++)
    begin : g_cell
        logic [SYM_W-1:0] right_sym;
        if (i == MAX_SYMBOLS - 1)
        begin : g_end
            assign right_sym = '0;
        end
        else
        begin : g_mid
            assign right_sym = cell_sym[i + 1];
        end

        kpu_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .right (right_sym),
            .sym   (cell_sym[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign digit     = digit_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    // An error word is always the only, and so the last, word of its item.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last)
        else $error("error word without last");

    // A good item never emits the empty symbol.
    a_digit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> digit != '0)
        else $error("zero digit on a good word");

    // A rejected item goes straight to the error state.
    a_bad_to_err: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_bad |=> state_reg == ST_ERR)
        else $error("bad item not routed to error");

    // The position counter never exceeds the row of cells while running.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> rem_reg < SYM_W'(MAX_SYMBOLS))
        else $error("position counter out of range");

    // The remaining rank stays below the factorial of the unused symbol count.
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> r_reg < RANK_W'(fact_rem * RANK_W'(rem_reg + SYM_W'(1))))
        else $error("remaining rank out of bounds");

endmodule

// ===== tb/sv/kth_permutation_unrank_checker.sv =====
// Checker for the permutation unranker: watches both channels, predicts the output words.
// Compares each output word against its prediction. Depends on kpu_pkg for field widths.
`timescale 1ns / 1ps

module kth_permutation_unrank_checker
    import kpu_pkg::*;
#(
    parameter int MAX_SYMBOLS = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [SYM_W-1:0]  count,
    input  logic [RANK_W-1:0] rank,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [SYM_W-1:0]  digit,
    input  logic              last,
    input  logic              error,
    output int                fail_count,
    output int                pending_words
);

    typedef struct packed {
        logic [SYM_W-1:0] digit;
        logic             last;
        logic             error;
    } perm_word_t;

    perm_word_t expected_words[$];

    initial begin
        fail_count    = 0;
        pending_words = 0;
    end

    function automatic int unsigned factorial(int unsigned m);
        int unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= m; i++)
            f = f * i;
        return f;
    endfunction

    // Appends one predicted word at the tail of the expected queue.
    function automatic void queue_word(input perm_word_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Factorial-base unranking: with rank - 1 as the remainder, each position
    // takes the (remainder / (m-1)!)-th smallest unused symbol.
    function automatic void predict_permutation(input logic [SYM_W-1:0] n,
                                                input logic [RANK_W-1:0] k);
        perm_word_t  w;
        logic [15:0] taken;
        int unsigned cnt;
        int unsigned rest;
        int unsigned place;
        int unsigned sel;
        cnt = 32'(n);
        if (cnt == 0 || cnt > MAX_SYMBOLS || k == 0 || k > factorial(cnt)) begin
            w.digit = '0;
            w.last  = 1'b1;
            w.error = 1'b1;
            queue_word(w);
            return;
        end
        taken = '0;
        rest  = 32'(k) - 1;
        for (int unsigned p = 0; p < cnt; p++) begin
            place   = factorial(cnt - 1 - p);
            sel     = rest / place;
            rest    = rest % place;
            w.digit = '0;
            for (int unsigned s = 1; s <= cnt; s++) begin
                if (!taken[s]) begin
                    if (sel == 0) begin
                        w.digit = s[SYM_W-1:0];
                        break;
                    end
                    sel--;
                end
            end
            taken[w.digit] = 1'b1;
            w.last  = (p == cnt - 1);
            w.error = 1'b0;
            queue_word(w);
        end
    endfunction

    function automatic void note_failure();
        fail_count++;
    endfunction

    always @(posedge clk) begin
        perm_word_t want;
        if (rst_n) begin
            if (in_valid && !in_stall)
                predict_permutation(count, rank);
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: digit %0d last %0d error %0d",
                           digit, last, error);
                    note_failure();
                end
                else begin
                    want = expected_words.pop_front();
                    if (digit !== want.digit) begin
                        $error("digit: expected %0d, got %0d", want.digit, digit);
                        note_failure();
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        note_failure();
                    end
                    if (error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, error);
                        note_failure();
                    end
                end
            end
            pending_words = expected_words.size();
        end
    end

endmodule

// ===== tb/sv/kth_permutation_unrank_top_tb.sv =====
// Testbench top for the permutation unranker: clock, reset, stimulus and verdict.
// Depends on kpu_pkg, kth_permutation_unrank_top and kth_permutation_unrank_checker.
`timescale 1ns / 1ps

module kth_permutation_unrank_top_tb
    import kpu_pkg::*;
();

    localparam int MAX_SYMBOLS   = 9;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES   = 80;
    // Random words per idling phase; with the directed words, about 380 in total.
    localparam int PHASE_WORDS   = 89;
    // Extra wait before the verdict, meant to cover the tail of the last item.
    localparam int DRAIN_CYCLES  = 12;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [SYM_W-1:0]  count     = '0;
    logic [RANK_W-1:0] rank      = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [SYM_W-1:0]  digit;
    logic              last;
    logic              error;

    int                fail_count;
    int                pending_words;

    // Idling rates in percent, changed by the stimulus process between phases.
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;

    // The stimulus asks for a hold-off by bumping holds_asked; the receiver
    // process serves it and counts its own cycles. One writer per counter.
    int unsigned       holds_asked  = 0;
    int unsigned       holds_served = 0;

    kth_permutation_unrank_top #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .count     (count),
        .rank      (rank),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .digit     (digit),
        .last      (last),
        .error     (error)
    );

    kth_permutation_unrank_checker #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .count         (count),
        .rank          (rank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .digit         (digit),
        .last          (last),
        .error         (error),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog. Stops the run and reports mismatches if the test never finishes,
    // with a wide margin over the slowest legal run.
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // Receiver side. Normally it stalls at random at the current rate; when a
    // hold-off is asked for, it keeps stall high for the whole hold-off while the
    // sender keeps offering words, so the block fills up and stalls its input.
    initial begin
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic int unsigned fact_value(int unsigned m);
        int unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= m; i++)
            f = f * i;
        return f;
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid is only
    // lowered when a gap is inserted, so back-to-back words keep it high with
    // a single assignment per time step.
    task automatic send_word(input logic [SYM_W-1:0] c, input logic [RANK_W-1:0] r);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        count    <= c;
        rank     <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Mostly well-formed requests with a random count and a random rank inside
    // 1..n!, plus ranks on the edges, ranks just past n!, a zero rank, and
    // pure noise over the full field widths.
    task automatic send_random_word();
        logic [SYM_W-1:0]  c;
        logic [RANK_W-1:0] r;
        int unsigned       pick;
        pick = $urandom_range(99);
        c    = SYM_W'($urandom_range(MAX_SYMBOLS, 1));
        r    = RANK_W'($urandom_range(fact_value(32'(c)), 1));
        if (pick < 8) begin
            c = SYM_W'($urandom);
            r = RANK_W'($urandom);
        end
        else if (pick < 12)
            r = RANK_W'(fact_value(32'(c)) + 1);
        else if (pick < 14)
            r = '0;
        else if (pick < 17)
            r = RANK_W'(fact_value(32'(c)));
        else if (pick < 19)
            r = RANK_W'(1);
        send_word(c, r);
    endtask

    // Stops offering and waits until every predicted word has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: bad counts, bad ranks, the first and last rank of
        // several sizes, and the largest count at both ends of its range.
        send_word(4'd0,  19'd1);
        send_word(4'd10, 19'd1);
        send_word(4'd15, 19'h7FFFF);
        send_word(4'd1,  19'd1);
        send_word(4'd1,  19'd2);
        send_word(4'd3,  19'd0);
        send_word(4'd2,  19'd1);
        send_word(4'd2,  19'd2);
        send_word(4'd3,  19'd1);
        send_word(4'd3,  19'd4);
        send_word(4'd3,  19'd6);
        send_word(4'd3,  19'd7);
        send_word(4'd4,  19'd24);
        send_word(4'd4,  19'd25);
        send_word(4'd5,  19'd60);
        send_word(4'd6,  19'd1);
        send_word(4'd7,  19'd5040);
        send_word(4'd8,  19'd40320);
        send_word(4'd8,  19'd40321);
        send_word(4'd9,  19'd1);
        send_word(4'd9,  19'd362880);
        send_word(4'd9,  19'd362881);
        send_word(4'd9,  19'h7FFFF);
        send_word(4'd9,  19'd181440);
        wait_drained();

        // Phase without idling; it opens with a long receiver hold-off so the
        // block backs up while the sender keeps pushing.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked++;
        repeat (PHASE_WORDS) send_random_word();
        wait_drained();

        // Sender idles most of the time.
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        repeat (PHASE_WORDS) send_random_word();
        wait_drained();

        // Receiver stalls most of the time.
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        repeat (PHASE_WORDS) send_random_word();
        wait_drained();

        // Both sides idle part of the time.
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        repeat (PHASE_WORDS) send_random_word();
        wait_drained();

        // Let any stray word show up before giving the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
